[rtl/saptk_pkg.sv]
// Package for the strongest access-point table.
// Field widths, function codes, sequencer states and the stored entry type.
// No dependencies.
package saptk_pkg;

  localparam int ADDR_W  = 48;
  localparam int STR_W   = 8;
  localparam int TOTAL_W = 5;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DONE   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_SCAN     = 4'b0010,
    S_RD_ISSUE = 4'b0100,
    S_RD_WAIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic signed [STR_W-1:0] str;
  } entry_t;

endpackage

[rtl/strongest_ap_topk_table.sv]
// Top level of the strongest access-point table: sequencer, compare unit, output register.
// Depends on saptk_pkg and saptk_ram.
//
//  channel | signals                                          | dir
//  in      | in_valid in_ready func station_addr strength       | sink
//  out     | out_valid out_ready entry_addr entry_strength      | source
//          | entry_valid entry_total last                       |
//
// Start and ignored codes are handled in the idle state. A report on an empty table
// is written straight to entry 0; else the table is read through the single RAM read
// port, one table read per cycle, with one address/strength compare per entry. A readout
// reads each entry, then loads it into the output register, or loads one empty result
// on an empty table, and stalls on out_ready.
// Reset clears the count and the sequencer; table contents are not cleared.
// in_ready is high only in the idle state; a pending result does not block input.
module strongest_ap_topk_table import saptk_pkg::*; #(
  parameter int MAX_APS = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic [ADDR_W-1:0]        station_addr,
  input  logic signed [STR_W-1:0]  strength,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ADDR_W-1:0]        entry_addr,
  output logic signed [STR_W-1:0]  entry_strength,
  output logic                     entry_valid,
  output logic [TOTAL_W-1:0]       entry_total,
  output logic                     last
);

  localparam int CW = $clog2(MAX_APS + 1);
  localparam int AW = (MAX_APS > 1) ? $clog2(MAX_APS) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_APS);

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic          cmp_vld, cmp_vld_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;
  logic          dup, dup_next;
  logic [AW-1:0] wk_idx, wk_idx_next;
  logic signed [STR_W-1:0] wk_str, wk_str_next;
  entry_t        item, item_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_rdata;

  logic          out_valid_next;
  entry_t        out_ent, out_ent_next;
  logic          out_ev, out_ev_next;
  logic          out_last, out_last_next;
  logic [CW-1:0] out_tot, out_tot_next;

  logic          in_fire, load_ok;
  logic          dup_now, wk_take, last_cmp;
  logic [AW-1:0] wk_idx_now;
  logic signed [STR_W-1:0] wk_str_now;

  saptk_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_APS)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (item_next),
    .rd_addr (idx[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign load_ok  = !out_valid || out_ready;

  // single compare unit, used by the report scan: one stored entry per cycle against the held report
  assign dup_now    = dup || (ram_rdata.addr == item.addr);
  assign wk_take    = (cmp_idx == '0) || (ram_rdata.str < wk_str);
  assign wk_idx_now = wk_take ? cmp_idx[AW-1:0] : wk_idx;
  assign wk_str_now = wk_take ? ram_rdata.str : wk_str;
  assign last_cmp   = (cmp_idx == cnt - CW'(1));

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    cmp_vld_next   = 1'b0;
    cmp_idx_next   = cmp_idx;
    dup_next       = dup;
    wk_idx_next    = wk_idx;
    wk_str_next    = wk_str;
    item_next      = item;
    ram_we         = 1'b0;
    ram_waddr      = cnt[AW-1:0];
    out_valid_next = out_valid && !out_ready;
    out_ent_next   = out_ent;
    out_ev_next    = out_ev;
    out_last_next  = out_last;
    out_tot_next   = out_tot;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_next = '0;
          dup_next = 1'b0;
          case (func)
            FUNC_START: cnt_next = '0;
            FUNC_REPORT: begin
              item_next.addr = station_addr;
              item_next.str  = strength;
              if (cnt == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                cnt_next  = CW'(1);
              end else begin
                state_next = S_SCAN;
              end
            end
            FUNC_DONE: state_next = (cnt == '0) ? S_RD_WAIT : S_RD_ISSUE;
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (idx < cnt) begin
          idx_next     = idx + CW'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = idx;
        end
        if (cmp_vld) begin
          dup_next    = dup_now;
          wk_idx_next = wk_idx_now;
          wk_str_next = wk_str_now;
          if (last_cmp) begin
            state_next   = S_IDLE;
            cmp_vld_next = 1'b0;
            if (!dup_now) begin
              if (cnt < MAX_C) begin
                ram_we    = 1'b1;
                ram_waddr = cnt[AW-1:0];
                cnt_next  = cnt + CW'(1);
              end else if (item.str > wk_str_now) begin
                ram_we    = 1'b1;
                ram_waddr = wk_idx_now;
              end
            end
          end
        end
      end

      S_RD_ISSUE: state_next = S_RD_WAIT;

      S_RD_WAIT: begin
        if (load_ok) begin
          out_valid_next = 1'b1;
          out_tot_next   = cnt;
          if (cnt == '0) begin
            out_ent_next  = '0;
            out_ev_next   = 1'b0;
            out_last_next = 1'b1;
            state_next    = S_IDLE;
          end else begin
            out_ent_next  = ram_rdata;
            out_ev_next   = 1'b1;
            out_last_next = (idx == cnt - CW'(1));
            if (idx == cnt - CW'(1)) begin
              state_next = S_IDLE;
            end else begin
              idx_next   = idx + CW'(1);
              state_next = S_RD_ISSUE;
            end
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      idx       <= idx_next;
      cmp_vld   <= cmp_vld_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx  <= cmp_idx_next;
    dup      <= dup_next;
    wk_idx   <= wk_idx_next;
    wk_str   <= wk_str_next;
    item     <= item_next;
    out_ent  <= out_ent_next;
    out_ev   <= out_ev_next;
    out_last <= out_last_next;
    out_tot  <= out_tot_next;
  end

  assign entry_addr     = out_ent.addr;
  assign entry_strength = out_ent.str;
  assign entry_valid    = out_ev;
  assign entry_total    = TOTAL_W'(out_tot);
  assign last           = out_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_C)
    else $error("fill count beyond table size");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt != '0))
    else $error("scan on empty table");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_SCAN) |-> (cmp_vld && last_cmp && !dup_now))
    else $error("table write before scan complete");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entry_valid) |-> (last && entry_total == '0))
    else $error("empty-table transaction malformed");

  a_scan_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1)))
    else $error("count jumped during scan");

endmodule

[rtl/saptk_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module saptk_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 20
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[tb/tb_strongest_ap_topk_table.sv]
// Testbench for strongest_ap_topk_table: random scans with start, report and done items,
// an in-bench model of the top-k table, and a field-by-field check of every readout.
// Depends on saptk_pkg and the strongest_ap_topk_table RTL.
module tb_strongest_ap_topk_table import saptk_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 20;
  localparam int SCAN_ITEMS = 410;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ADDR_W-1:0]       addr;
    logic signed [STR_W-1:0] str;
  } scan_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       addr;
    logic signed [STR_W-1:0] str;
    logic                    valid;
    logic [TOTAL_W-1:0]      total;
    logic                    last;
  } readout_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [FUNC_W-1:0]       func = FUNC_START;
  logic [ADDR_W-1:0]       station_addr = '0;
  logic signed [STR_W-1:0] strength = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ADDR_W-1:0]       entry_addr;
  logic signed [STR_W-1:0] entry_strength;
  logic                    entry_valid;
  logic [TOTAL_W-1:0]      entry_total;
  logic                    last;

  scan_item_t scan_items_q[$];
  readout_t   readout_q[$];

  // model of the table
  logic [ADDR_W-1:0]       ap_addr [TABLE_DEPTH];
  logic signed [STR_W-1:0] ap_str  [TABLE_DEPTH];
  int                      ap_count = 0;

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  items_queued = 0;
  int  items_taken = 0;
  int  send_gap_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_took = 1'b0;

  strongest_ap_topk_table #(.MAX_APS(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .station_addr(station_addr),
    .strength(strength),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .entry_addr(entry_addr),
    .entry_strength(entry_strength),
    .entry_valid(entry_valid),
    .entry_total(entry_total),
    .last(last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH @%0d: %s", cycle_cnt, what);
  endtask

  function automatic void predict_scan_item(input scan_item_t it);
    int  weakest;
    bit  dup;
    readout_t r;
    dup = 1'b0;
    case (it.func)
      FUNC_START: ap_count = 0;
      FUNC_REPORT: begin
        for (int i = 0; i < ap_count; i++) if (ap_addr[i] == it.addr) dup = 1'b1;
        if (!dup) begin
          if (ap_count < TABLE_DEPTH) begin
            ap_addr[ap_count] = it.addr;
            ap_str[ap_count] = it.str;
            ap_count++;
          end else begin
            weakest = 0;
            for (int i = 1; i < TABLE_DEPTH; i++) if (ap_str[i] < ap_str[weakest]) weakest = i;
            if (it.str > ap_str[weakest]) begin
              ap_addr[weakest] = it.addr;
              ap_str[weakest] = it.str;
            end
          end
        end
      end
      FUNC_DONE: begin
        if (ap_count == 0) begin
          r = '0;
          r.last = 1'b1;
          readout_q.push_back(r);
        end else begin
          for (int k = 0; k < ap_count; k++) begin
            r.addr = ap_addr[k];
            r.str = ap_str[k];
            r.valid = 1'b1;
            r.total = TOTAL_W'(ap_count);
            r.last = (k == ap_count - 1);
            readout_q.push_back(r);
          end
        end
      end
      default: ; // unused code: no effect
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void queue_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                                     input logic signed [STR_W-1:0] s);
    scan_item_t it;
    it.func = f;
    it.addr = a;
    it.str = s;
    scan_items_q.push_back(it);
    if (f != FUNC_UNUSED) items_queued++;
  endfunction

  // driver: new transaction presented at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_took) begin
        if (scan_items_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          func <= scan_items_q[0].func;
          station_addr <= scan_items_q[0].addr;
          strength <= scan_items_q[0].str;
          void'(scan_items_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: inputs and outputs sampled at the rising edge
  always @(posedge clk) begin
    scan_item_t it;
    readout_t   r;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end else if (!rst) begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        it.func = func;
        it.addr = station_addr;
        it.str = strength;
        predict_scan_item(it);
        items_taken++;
        case (items_taken * 4 / (items_queued + 1))
          0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
          2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
          default: begin send_gap_pct = 11; recv_stall_pct = 11; end
        endcase
      end
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          r = readout_q.pop_front();
          if (entry_addr !== r.addr)
            report_mismatch($sformatf("entry_addr %h, want %h", entry_addr, r.addr));
          if (entry_strength !== r.str)
            report_mismatch($sformatf("entry_strength %0d, want %0d", entry_strength, r.str));
          if (entry_valid !== r.valid)
            report_mismatch($sformatf("entry_valid %b, want %b", entry_valid, r.valid));
          if (entry_total !== r.total)
            report_mismatch($sformatf("entry_total %0d, want %0d", entry_total, r.total));
          if (last !== r.last)
            report_mismatch($sformatf("last %b, want %b", last, r.last));
        end
      end
    end
  end

  initial begin
    int n;
    int pool;
    bit narrow;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    logic signed [STR_W-1:0] s;

    // directed: report before any start, empty readout, extremes, duplicates, repeat readout
    queue_item(FUNC_REPORT, '1, 8'sd127);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_UNUSED, '1, '1);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_START, '1, '1);
    queue_item(FUNC_DONE, '1, '1);
    queue_item(FUNC_REPORT, '0, -8'sd128);
    queue_item(FUNC_REPORT, 48'h5555_5555_5555, 8'sd0);
    queue_item(FUNC_REPORT, 48'hAAAA_AAAA_AAAA, -8'sd1);
    queue_item(FUNC_REPORT, '0, 8'sd127);               // known address, stronger: ignored
    queue_item(FUNC_REPORT, 48'hAAAA_AAAA_AAAA, 8'sd1);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_UNUSED, 48'h5555_5555_5555, 8'sd85);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_START, '0, '0);
    queue_item(FUNC_REPORT, 48'h0000_0000_0001, 8'sd64);
    queue_item(FUNC_DONE, '0, '0);
    queue_item(FUNC_START, '0, '0);
    queue_item(FUNC_DONE, '0, '0);

    // random scans, mostly well formed, a few with enough reports to fill the table
    while (items_queued < SCAN_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        queue_item(FUNC_START, rand_addr(), STR_W'($urandom));
        n = ($urandom_range(3) == 0) ? $urandom_range(18, 32) : $urandom_range(0, 10);
        pool = n + 1;
        base = rand_addr();
        narrow = 1'($urandom_range(1));
        for (int j = 0; j < n; j++) begin
          a = ($urandom_range(3) == 0) ? rand_addr() : base ^ ADDR_W'($urandom_range(pool));
          // a narrow strength band gives plenty of ties and equal-strength reports
          s = narrow ? STR_W'(-60 - int'($urandom_range(6))) : STR_W'($urandom);
          queue_item(FUNC_REPORT, a, s);
        end
        queue_item(FUNC_DONE, rand_addr(), STR_W'($urandom));
        if ($urandom_range(3) == 0) queue_item(FUNC_DONE, rand_addr(), STR_W'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        for (int j = 0; j < n; j++)
          queue_item(FUNC_W'($urandom_range(3)), rand_addr(), STR_W'($urandom));
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (scan_items_q.size() > 0 || in_valid) @(posedge clk);
    while (readout_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (readout_q.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", readout_q.size()));

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
